>>> src/cme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_pkg
// opcodes, fault codes, emit codes and the request to the iterative unit
// ----------------------------------------------------------------------------
package cme_pkg;

	localparam logic [5:0] K_QUIT   = 6'd0;
	localparam logic [5:0] K_WRITE  = 6'd1;
	localparam logic [5:0] K_COPY   = 6'd2;
	localparam logic [5:0] K_PRNUM  = 6'd4;
	localparam logic [5:0] K_PRCHR  = 6'd5;
	localparam logic [5:0] K_NEWCTX = 6'd7;
	localparam logic [5:0] K_DROPCX = 6'd8;
	localparam logic [5:0] K_PUSHA  = 6'd9;
	localparam logic [5:0] K_POPA   = 6'd10;
	localparam logic [5:0] K_PUSHR  = 6'd11;
	localparam logic [5:0] K_POPR   = 6'd12;
	localparam logic [5:0] K_CALL   = 6'd13;
	localparam logic [5:0] K_RET    = 6'd14;
	localparam logic [5:0] K_JUMP   = 6'd15;
	localparam logic [5:0] K_RDPC   = 6'd16;
	localparam logic [5:0] K_ADD    = 6'd24;
	localparam logic [5:0] K_SUB    = 6'd25;
	localparam logic [5:0] K_MUL    = 6'd26;
	localparam logic [5:0] K_DIV    = 6'd27;
	localparam logic [5:0] K_MOD    = 6'd28;
	localparam logic [5:0] K_RANGE  = 6'd29;
	localparam logic [5:0] K_NOT    = 6'd30;

	localparam logic [2:0] FLT_NONE = 3'd0;
	localparam logic [2:0] FLT_PC   = 3'd1;
	localparam logic [2:0] FLT_OP   = 3'd2;
	localparam logic [2:0] FLT_IDX  = 3'd3;
	localparam logic [2:0] FLT_CTX  = 3'd4;
	localparam logic [2:0] FLT_OVF  = 3'd5;
	localparam logic [2:0] FLT_UNF  = 3'd6;
	localparam logic [2:0] FLT_SIZE = 3'd7;

	localparam logic [1:0] EMIT_NONE = 2'd0;
	localparam logic [1:0] EMIT_NUM  = 2'd1;
	localparam logic [1:0] EMIT_CHR  = 2'd2;

	typedef struct packed {
		logic start;
		logic is_div;
		logic want_rem;
	} md_req_t;

endpackage

>>> src/cme_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_muldiv
// bit-serial 64-bit multiply (low half) and restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module cme_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  cme_pkg::md_req_t  req,
	input  logic [63:0]       op_a,
	input  logic [63:0]       op_b,
	output logic              done,
	output logic [63:0]       result
);

	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic        rem_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] acc_q;
	logic [64:0] trial;

	assign trial = {acc_q, x_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			rem_q <= req.want_rem;
			x_q   <= op_a;
			y_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				// restoring step: shift in next dividend bit, subtract if it fits
				if (trial >= {1'b0, y_q}) begin
					acc_q <= 64'(trial - {1'b0, y_q});
					x_q   <= {x_q[62:0], 1'b1};
				end else begin
					acc_q <= trial[63:0];
					x_q   <= {x_q[62:0], 1'b0};
				end
			end else begin
				if (x_q[0]) begin
					acc_q <= acc_q + y_q;
				end
				x_q <= {1'b0, x_q[63:1]};
				y_q <= {y_q[62:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = (div_q && !rem_q) ? x_q : acc_q;

endmodule

>>> src/cell_machine_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_machine_execute_unit
// executes one register-cell machine instruction per input word
// ----------------------------------------------------------------------------
// sequence: accept in S_IDLE, operand fetch in S_RA, S_RB, S_RC and S_CC, then S_EXEC
// and S_OUT; mul, div and mod wait in S_MD for the shared bit-serial unit; once halted
// a word goes from S_IDLE straight to S_OUT; one word at a time, next word taken
// after the result is loaded into the output register
// reset: asynchronous active-low; pc 0, running, no contexts, stacks empty
// ----------------------------------------------------------------------------
module cell_machine_execute_unit #(
	parameter int CELLS_PER_CONTEXT = 16,
	parameter int CONTEXT_DEPTH     = 8,
	parameter int VALUE_STACK_DEPTH = 16,
	parameter int CALL_STACK_DEPTH  = 16,
	parameter int PC_WIDTH          = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: program length
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// instruction words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  kind,
	input  logic [63:0] immediate,
	input  logic [7:0]  src_a,
	input  logic [7:0]  src_b,
	input  logic [7:0]  src_c,
	input  logic [7:0]  dst_a,
	input  logic [7:0]  dst_b,
	input  logic [15:0] target_pc,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] next_pc,
	output logic        halted,
	output logic [2:0]  fault_code,
	output logic [1:0]  emit_kind,
	output logic [63:0] emit_value
);

	// index and counter widths
	localparam int CIW  = (CELLS_PER_CONTEXT > 1) ? $clog2(CELLS_PER_CONTEXT) : 1;
	localparam int RW   = (CONTEXT_DEPTH > 1) ? $clog2(CONTEXT_DEPTH) : 1;
	localparam int SW   = $clog2(CELLS_PER_CONTEXT + 1);
	localparam int CNTW = $clog2(CONTEXT_DEPTH + 1);
	localparam int VIW  = (VALUE_STACK_DEPTH > 1) ? $clog2(VALUE_STACK_DEPTH) : 1;
	localparam int VPW  = $clog2(VALUE_STACK_DEPTH + 1);
	localparam int KIW  = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;
	localparam int KPW  = $clog2(CALL_STACK_DEPTH + 1);
	localparam int CMPW = (PC_WIDTH > 16) ? PC_WIDTH : 16;

	typedef enum logic [2:0] {
		S_IDLE, S_RA, S_RB, S_RC, S_CC, S_EXEC, S_MD, S_OUT
	} state_t;

	state_t state_q;

	// architectural state
	logic [PC_WIDTH-1:0] pc_q;
	logic                halted_q;
	logic [2:0]          fault_q;
	logic [15:0]         prog_len_q;
	logic [CNTW-1:0]     ctx_cnt_q;
	logic [SW-1:0]       ctx_size_q [CONTEXT_DEPTH];
	logic [CELLS_PER_CONTEXT-1:0] cell_vld_q [CONTEXT_DEPTH];
	logic [VPW-1:0]      asp_q;
	logic [VPW-1:0]      rsp_q;
	logic [KPW-1:0]      csp_q;

	// memories
	logic [63:0]         cell_mem [CONTEXT_DEPTH][CELLS_PER_CONTEXT];
	logic [63:0]         arg_mem  [VALUE_STACK_DEPTH];
	logic [63:0]         res_mem  [VALUE_STACK_DEPTH];
	logic [PC_WIDTH-1:0] call_mem [CALL_STACK_DEPTH];

	// latched instruction
	logic [5:0]  kind_q;
	logic [63:0] imm_q;
	logic [7:0]  sa_q, sb_q, sc_q, da_q, db_q;
	logic [15:0] tgt_q;

	// operand fetch
	logic [63:0]         rd_data_q;
	logic                rd_vld_q;
	logic [63:0]         rd_value;
	logic [63:0]         a_q, b_q, c_q;
	logic [63:0]         atop_q, rtop_q;
	logic [PC_WIDTH-1:0] ctop_q;
	logic [7:0]          rd_idx;

	// result staging
	logic [1:0]          ek_q;
	logic [63:0]         ev_q;
	logic [PC_WIDTH-1:0] md_next_q;

	logic [RW-1:0] cur_row;
	logic [SW-1:0] cur_size;

	// execute decode
	logic [2:0]          ex_f;
	logic                ex_quit;
	logic                ex_we;
	logic [7:0]          ex_widx;
	logic [63:0]         ex_wdata;
	logic [PC_WIDTH-1:0] ex_next;
	logic [1:0]          ex_ek;
	logic [63:0]         ex_ev;
	logic                ex_push_ctx, ex_drop_ctx;
	logic                ex_push_a, ex_pop_a, ex_push_r, ex_pop_r;
	logic                ex_call, ex_ret;
	logic                ex_md;

	// shared unit
	cme_pkg::md_req_t md_req;
	logic             md_done;
	logic [63:0]      md_result;

	// cell write port
	logic          cell_we;
	logic [7:0]    cell_widx;
	logic [63:0]   cell_wdata;

	logic accept;
	logic out_load;
	logic out_valid_q;

	assign cur_row  = RW'(ctx_cnt_q - CNTW'(1));
	assign cur_size = ctx_size_q[cur_row];
	assign rd_value = rd_vld_q ? rd_data_q : 64'd0;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// cell access check: no context, then index beyond the context
	function automatic logic [2:0] chk(input logic [7:0] idx);
		logic [8:0] ix;
		ix = {1'b0, idx};
		if (ctx_cnt_q == '0) return cme_pkg::FLT_CTX;
		if (ix >= 9'(cur_size) || ix >= 9'(CELLS_PER_CONTEXT)) return cme_pkg::FLT_IDX;
		return cme_pkg::FLT_NONE;
	endfunction

	// read index per fetch state
	always_comb begin
		case (state_q)
			S_RB:    rd_idx = sb_q;
			S_RC:    rd_idx = sc_q;
			default: rd_idx = sa_q;
		endcase
	end

	// instruction decode and checks, all operands present
	always_comb begin
		ex_f        = cme_pkg::FLT_NONE;
		ex_quit     = 1'b0;
		ex_we       = 1'b0;
		ex_widx     = da_q;
		ex_wdata    = 64'd0;
		ex_next     = pc_q + PC_WIDTH'(1);
		ex_ek       = cme_pkg::EMIT_NONE;
		ex_ev       = 64'd0;
		ex_push_ctx = 1'b0;
		ex_drop_ctx = 1'b0;
		ex_push_a   = 1'b0;
		ex_pop_a    = 1'b0;
		ex_push_r   = 1'b0;
		ex_pop_r    = 1'b0;
		ex_call     = 1'b0;
		ex_ret      = 1'b0;
		ex_md       = 1'b0;
		if (CMPW'(pc_q) >= CMPW'(prog_len_q)) begin
			ex_f = cme_pkg::FLT_PC;
		end else begin
			case (kind_q)
				cme_pkg::K_QUIT: ex_quit = 1'b1;
				cme_pkg::K_WRITE: begin
					ex_f     = chk(da_q);
					ex_we    = 1'b1;
					ex_wdata = imm_q;
				end
				cme_pkg::K_COPY: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(da_q);
					ex_we    = 1'b1;
					ex_wdata = a_q;
				end
				cme_pkg::K_PRNUM: begin
					ex_f  = chk(sa_q);
					ex_ek = cme_pkg::EMIT_NUM;
					ex_ev = a_q;
				end
				cme_pkg::K_PRCHR: begin
					ex_f  = chk(sa_q);
					ex_ek = cme_pkg::EMIT_CHR;
					ex_ev = {56'd0, a_q[7:0]};
				end
				cme_pkg::K_NEWCTX: begin
					if (imm_q > 64'(CELLS_PER_CONTEXT)) ex_f = cme_pkg::FLT_SIZE;
					else if (ctx_cnt_q >= CNTW'(CONTEXT_DEPTH)) ex_f = cme_pkg::FLT_OVF;
					else ex_push_ctx = 1'b1;
				end
				cme_pkg::K_DROPCX: ex_drop_ctx = (ctx_cnt_q != '0);
				cme_pkg::K_PUSHA: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE && asp_q >= VPW'(VALUE_STACK_DEPTH))
						ex_f = cme_pkg::FLT_OVF;
					ex_push_a = 1'b1;
				end
				cme_pkg::K_PUSHR: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE && rsp_q >= VPW'(VALUE_STACK_DEPTH))
						ex_f = cme_pkg::FLT_OVF;
					ex_push_r = 1'b1;
				end
				cme_pkg::K_POPA: begin
					ex_f = chk(da_q);
					if (ex_f == cme_pkg::FLT_NONE && asp_q == '0) ex_f = cme_pkg::FLT_UNF;
					ex_pop_a = 1'b1;
					ex_we    = 1'b1;
					ex_wdata = atop_q;
				end
				cme_pkg::K_POPR: begin
					ex_f = chk(da_q);
					if (ex_f == cme_pkg::FLT_NONE && rsp_q == '0) ex_f = cme_pkg::FLT_UNF;
					ex_pop_r = 1'b1;
					ex_we    = 1'b1;
					ex_wdata = rtop_q;
				end
				cme_pkg::K_CALL: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE && csp_q >= KPW'(CALL_STACK_DEPTH))
						ex_f = cme_pkg::FLT_OVF;
					if (ex_f == cme_pkg::FLT_NONE && (a_q >> PC_WIDTH) != 64'd0)
						ex_f = cme_pkg::FLT_PC;
					ex_call = 1'b1;
					ex_next = a_q[PC_WIDTH-1:0];
				end
				cme_pkg::K_RET: begin
					if (csp_q == '0) ex_f = cme_pkg::FLT_UNF;
					ex_ret  = 1'b1;
					ex_next = ctop_q;
				end
				cme_pkg::K_JUMP: begin
					ex_f = chk(sa_q);
					if (a_q == 64'd1) ex_next = PC_WIDTH'(tgt_q);
				end
				cme_pkg::K_RDPC: begin
					ex_f     = chk(da_q);
					ex_we    = 1'b1;
					ex_wdata = 64'(pc_q);
				end
				cme_pkg::K_ADD, cme_pkg::K_SUB, cme_pkg::K_MUL,
				cme_pkg::K_DIV, cme_pkg::K_MOD: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(sb_q);
					if (ex_f == cme_pkg::FLT_NONE) begin
						if ((kind_q == cme_pkg::K_DIV || kind_q == cme_pkg::K_MOD)
							&& b_q == 64'd0) begin
							// zero divisor: flag into dst_b, dst_a untouched
							ex_f     = chk(db_q);
							ex_we    = 1'b1;
							ex_widx  = db_q;
							ex_wdata = 64'd1;
						end else begin
							ex_f = chk(da_q);
							if (kind_q == cme_pkg::K_ADD) begin
								ex_we    = 1'b1;
								ex_wdata = a_q + b_q;
							end else if (kind_q == cme_pkg::K_SUB) begin
								ex_we    = 1'b1;
								ex_wdata = a_q - b_q;
							end else begin
								ex_md = 1'b1;
							end
						end
					end
				end
				cme_pkg::K_RANGE: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(sb_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(sc_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(da_q);
					ex_we    = 1'b1;
					ex_wdata = {63'd0, (b_q >= a_q) && (b_q <= c_q)};
				end
				cme_pkg::K_NOT: begin
					ex_f = chk(sa_q);
					if (ex_f == cme_pkg::FLT_NONE) ex_f = chk(da_q);
					ex_we    = 1'b1;
					ex_wdata = {63'd0, a_q == 64'd0};
				end
				default: ex_f = cme_pkg::FLT_OP;
			endcase
		end
	end

	// start the shared unit only for a clean mul, div or mod
	assign md_req.start    = (state_q == S_EXEC) && ex_md && (ex_f == cme_pkg::FLT_NONE);
	assign md_req.is_div   = (kind_q != cme_pkg::K_MUL);
	assign md_req.want_rem = (kind_q == cme_pkg::K_MOD);

	cme_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.op_a   (a_q),
		.op_b   (b_q),
		.done   (md_done),
		.result (md_result)
	);

	// one cell write port, shared by execute and the shared unit's finish
	assign cell_we    = ((state_q == S_EXEC) && ex_we && (ex_f == cme_pkg::FLT_NONE))
	                    || ((state_q == S_MD) && md_done);
	assign cell_widx  = (state_q == S_MD) ? da_q : ex_widx;
	assign cell_wdata = (state_q == S_MD) ? md_result : ex_wdata;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			fault_q     <= cme_pkg::FLT_NONE;
			prog_len_q  <= '0;
			ctx_cnt_q   <= '0;
			asp_q       <= '0;
			rsp_q       <= '0;
			csp_q       <= '0;
			out_valid_q <= 1'b0;
			ek_q        <= cme_pkg::EMIT_NONE;
			for (int r = 0; r < CONTEXT_DEPTH; r++) begin
				ctx_size_q[r] <= '0;
				cell_vld_q[r] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) prog_len_q <= cfg_data;
			// result word held until taken, new one loaded from S_OUT
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cell_we) cell_vld_q[cur_row][CIW'(cell_widx)] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ek_q    <= cme_pkg::EMIT_NONE;
						// once halted every word is answered with the held status
						state_q <= halted_q ? S_OUT : S_RA;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: state_q <= S_RC;
				S_RC: state_q <= S_CC;
				S_CC: state_q <= S_EXEC;
				S_EXEC: begin
					if (ex_f != cme_pkg::FLT_NONE) begin
						halted_q <= 1'b1;
						fault_q  <= ex_f;
						state_q  <= S_OUT;
					end else if (ex_md) begin
						state_q <= S_MD;
					end else begin
						pc_q <= ex_next;
						ek_q <= ex_ek;
						if (ex_quit) begin
							halted_q <= 1'b1;
							fault_q  <= cme_pkg::FLT_NONE;
						end
						if (ex_push_ctx) begin
							ctx_size_q[RW'(ctx_cnt_q)] <= SW'(imm_q);
							cell_vld_q[RW'(ctx_cnt_q)] <= '0;
							ctx_cnt_q <= ctx_cnt_q + CNTW'(1);
						end
						if (ex_drop_ctx) ctx_cnt_q <= ctx_cnt_q - CNTW'(1);
						if (ex_push_a) asp_q <= asp_q + VPW'(1);
						if (ex_pop_a)  asp_q <= asp_q - VPW'(1);
						if (ex_push_r) rsp_q <= rsp_q + VPW'(1);
						if (ex_pop_r)  rsp_q <= rsp_q - VPW'(1);
						if (ex_call)   csp_q <= csp_q + KPW'(1);
						if (ex_ret)    csp_q <= csp_q - KPW'(1);
						state_q <= S_OUT;
					end
				end
				S_MD: begin
					if (md_done) begin
						pc_q    <= md_next_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			imm_q  <= immediate;
			sa_q   <= src_a;
			sb_q   <= src_b;
			sc_q   <= src_c;
			da_q   <= dst_a;
			db_q   <= dst_b;
			tgt_q  <= target_pc;
		end
		if (state_q == S_RB) a_q <= rd_value;
		if (state_q == S_RC) b_q <= rd_value;
		if (state_q == S_CC) c_q <= rd_value;
		if (state_q == S_EXEC) begin
			ev_q      <= ex_ev;
			md_next_q <= pc_q + PC_WIDTH'(1);
		end
		if (out_load) begin
			next_pc    <= 16'(pc_q);
			halted     <= halted_q;
			fault_code <= fault_q;
			emit_kind  <= ek_q;
			emit_value <= (ek_q == cme_pkg::EMIT_NONE) ? 64'd0 : ev_q;
		end
	end

	// cell memory: one registered read, one write
	always_ff @(posedge clk) begin
		rd_data_q <= cell_mem[cur_row][CIW'(rd_idx)];
		rd_vld_q  <= cell_vld_q[cur_row][CIW'(rd_idx)];
		if (cell_we) cell_mem[cur_row][CIW'(cell_widx)] <= cell_wdata;
	end

	// stack memories: top read registered during fetch, push on commit
	always_ff @(posedge clk) begin
		if (state_q == S_RA) begin
			atop_q <= arg_mem[VIW'(asp_q - VPW'(1))];
			rtop_q <= res_mem[VIW'(rsp_q - VPW'(1))];
			ctop_q <= call_mem[KIW'(csp_q - KPW'(1))];
		end
		if (state_q == S_EXEC && ex_f == cme_pkg::FLT_NONE) begin
			if (ex_push_a) arg_mem[VIW'(asp_q)] <= a_q;
			if (ex_push_r) res_mem[VIW'(rsp_q)] <= a_q;
			if (ex_call)   call_mem[KIW'(csp_q)] <= pc_q + PC_WIDTH'(1);
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/cme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cme_checker
// port-level checks of the execute unit, bound into the execute unit module
// ----------------------------------------------------------------------------
module cme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] next_pc,
	input logic        halted,
	input logic [1:0]  emit_kind,
	input logic [63:0] emit_value
);

	// a word in flight blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted while previous still executing");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(emit_value))
		else $error("stalled result changed");

	// halting never comes with an emit
	a_halt_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |-> emit_kind == 2'd0)
		else $error("emit on halted result");

	// no emit means a zero value, and the emit code stays in range
	a_emit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> emit_kind != 2'd3 && (emit_kind != 2'd0 || emit_value == 64'd0))
		else $error("bad emit word");

endmodule

bind cell_machine_execute_unit cme_checker u_cme_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.next_pc    (next_pc),
	.halted     (halted),
	.emit_kind  (emit_kind),
	.emit_value (emit_value)
);

>>> test/cell_machine_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_machine_execute_unit_tb
// drives instruction words through the execute unit and checks every result
// word against a predictor that keeps its own copy of the machine state, or
// against a fixed expectation for the directed rows that carry one: directed
// table first, then random well-formed programs over several program lengths
// and idling phases, and a single halting word followed by words that must be ignored
module cell_machine_execute_unit_tb;

	localparam int NCELL     = 16;
	localparam int NCTX      = 8;
	localparam int NVAL      = 16;
	localparam int NRET      = 16;
	localparam int DRAIN     = 100;	// longer than the slowest word takes through the unit
	localparam int WD_LIMIT  = 5000;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 225;
	localparam int NDIR      = 25;

	typedef struct packed {
		logic [5:0]  kind;
		logic [63:0] imm;
		logic [7:0]  sa, sb, sc, da, db;
		logic [15:0] tpc;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic [2:0]  fault_code;
		logic [1:0]  emit_kind;
		logic [63:0] emit_value;
	} retire_t;

	// dut signals, inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [5:0]  kind = '0;
	logic [63:0] immediate = '0;
	logic [7:0]  src_a = '0, src_b = '0, src_c = '0, dst_a = '0, dst_b = '0;
	logic [15:0] target_pc = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] next_pc;
	logic        halted;
	logic [2:0]  fault_code;
	logic [1:0]  emit_kind;
	logic [63:0] emit_value;

	cell_machine_execute_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .immediate(immediate),
		.src_a(src_a), .src_b(src_b), .src_c(src_c), .dst_a(dst_a), .dst_b(dst_b),
		.target_pc(target_pc),
		.out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc), .halted(halted),
		.fault_code(fault_code), .emit_kind(emit_kind), .emit_value(emit_value)
	);

	always #10 clk = ~clk;

	// machine state as the predictor sees it
	logic [63:0] cells [NCTX][NCELL];
	logic [4:0]  ctx_size [NCTX];
	int          ctx = 0;
	logic [63:0] arg_stk [NVAL];
	logic [63:0] res_stk [NVAL];
	logic [15:0] ret_stk [NRET];
	int          arg_sp = 0, res_sp = 0, ret_sp = 0;
	logic [15:0] pc = '0;
	bit          halt = 0;
	logic [2:0]  flt = cme_pkg::FLT_NONE;
	logic [15:0] prog_len = '0;

	retire_t retire_q [$];
	int      errors = 0;
	int      gap_pct = 0, stall_pct = 0;
	int      idle_cycles = 0;

	// directed table
	instr_t  dir_word [NDIR];
	bit      dir_typed [NDIR];
	retire_t dir_want [NDIR];

	function automatic logic [2:0] cell_chk(input logic [7:0] i);
		if (ctx == 0)
			return cme_pkg::FLT_CTX;
		if (i >= ctx_size[ctx-1] || i >= NCELL)
			return cme_pkg::FLT_IDX;
		return cme_pkg::FLT_NONE;
	endfunction

	function automatic logic [63:0] cell_rd(input logic [7:0] i);
		return cells[ctx-1][i[3:0]];
	endfunction

	// works out the result word of one instruction; commits state when apply is set
	function automatic retire_t vm_execute(input instr_t w, input bit apply);
		retire_t     r;
		logic [2:0]  f;
		logic [63:0] nxt, x, y, wv, pv;
		logic [7:0]  wi;
		logic [1:0]  ek;
		logic [63:0] ev;
		bit          wr, quit, cpush, cpop, apush, apop, rpush, rpop, kpush, kpop;
		f = cme_pkg::FLT_NONE; nxt = 64'(pc) + 64'd1; x = '0; y = '0; wv = '0; pv = '0;
		wi = '0;
		ek = cme_pkg::EMIT_NONE; ev = '0;
		wr = 0; quit = 0; cpush = 0; cpop = 0; apush = 0; apop = 0;
		rpush = 0; rpop = 0; kpush = 0; kpop = 0;
		if (halt) begin
			r.next_pc = pc; r.halted = 1'b1; r.fault_code = flt;
			r.emit_kind = cme_pkg::EMIT_NONE; r.emit_value = '0;
			return r;
		end
		if (pc >= prog_len)
			f = cme_pkg::FLT_PC;
		else begin
			case (w.kind)
				cme_pkg::K_QUIT: quit = 1;
				cme_pkg::K_WRITE: begin
					f = cell_chk(w.da); wr = 1; wi = w.da; wv = w.imm;
				end
				cme_pkg::K_COPY: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.da);
					if (f == cme_pkg::FLT_NONE) begin wr = 1; wi = w.da; wv = cell_rd(w.sa); end
				end
				cme_pkg::K_PRNUM, cme_pkg::K_PRCHR: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE) begin
						ek = (w.kind == cme_pkg::K_PRNUM) ? cme_pkg::EMIT_NUM : cme_pkg::EMIT_CHR;
						ev = cell_rd(w.sa);
						if (w.kind == cme_pkg::K_PRCHR) ev = {56'd0, ev[7:0]};
					end
				end
				cme_pkg::K_NEWCTX: begin
					if (w.imm > NCELL) f = cme_pkg::FLT_SIZE;
					else if (ctx >= NCTX) f = cme_pkg::FLT_OVF;
					else cpush = 1;
				end
				cme_pkg::K_DROPCX: cpop = (ctx > 0);	// dropping with nothing open is ignored
				cme_pkg::K_PUSHA, cme_pkg::K_PUSHR: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE
						&& ((w.kind == cme_pkg::K_PUSHA) ? arg_sp : res_sp) >= NVAL)
						f = cme_pkg::FLT_OVF;
					if (f == cme_pkg::FLT_NONE) begin
						pv = cell_rd(w.sa);
						if (w.kind == cme_pkg::K_PUSHA) apush = 1; else rpush = 1;
					end
				end
				cme_pkg::K_POPA, cme_pkg::K_POPR: begin
					f = cell_chk(w.da);
					if (f == cme_pkg::FLT_NONE
						&& ((w.kind == cme_pkg::K_POPA) ? arg_sp : res_sp) == 0)
						f = cme_pkg::FLT_UNF;
					if (f == cme_pkg::FLT_NONE) begin
						wr = 1; wi = w.da;
						if (w.kind == cme_pkg::K_POPA) begin apop = 1; wv = arg_stk[arg_sp-1]; end
						else begin rpop = 1; wv = res_stk[res_sp-1]; end
					end
				end
				cme_pkg::K_CALL: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE && ret_sp >= NRET) f = cme_pkg::FLT_OVF;
					if (f == cme_pkg::FLT_NONE && cell_rd(w.sa) > 64'hFFFF) f = cme_pkg::FLT_PC;
					if (f == cme_pkg::FLT_NONE) begin kpush = 1; nxt = cell_rd(w.sa); end
				end
				cme_pkg::K_RET: begin
					if (ret_sp == 0) f = cme_pkg::FLT_UNF;
					else begin kpop = 1; nxt = 64'(ret_stk[ret_sp-1]); end
				end
				cme_pkg::K_JUMP: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE && cell_rd(w.sa) == 64'd1) nxt = 64'(w.tpc);
				end
				cme_pkg::K_RDPC: begin
					f = cell_chk(w.da); wr = 1; wi = w.da; wv = 64'(pc);
				end
				cme_pkg::K_ADD, cme_pkg::K_SUB, cme_pkg::K_MUL, cme_pkg::K_DIV,
				cme_pkg::K_MOD: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.sb);
					if (f == cme_pkg::FLT_NONE) begin
						x = cell_rd(w.sa); y = cell_rd(w.sb);
						if ((w.kind == cme_pkg::K_DIV || w.kind == cme_pkg::K_MOD) && y == 0) begin
							// zero divisor: flag goes to the secondary cell only
							f = cell_chk(w.db); wr = 1; wi = w.db; wv = 64'd1;
						end else begin
							f = cell_chk(w.da); wr = 1; wi = w.da;
							case (w.kind)
								cme_pkg::K_ADD: wv = x + y;
								cme_pkg::K_SUB: wv = x - y;
								cme_pkg::K_MUL: wv = x * y;
								cme_pkg::K_DIV: wv = x / y;
								default: wv = x % y;
							endcase
						end
					end
				end
				cme_pkg::K_RANGE: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.sb);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.sc);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.da);
					if (f == cme_pkg::FLT_NONE) begin
						x = cell_rd(w.sb); wr = 1; wi = w.da;
						wv = (x >= cell_rd(w.sa) && x <= cell_rd(w.sc)) ? 64'd1 : 64'd0;
					end
				end
				cme_pkg::K_NOT: begin
					f = cell_chk(w.sa);
					if (f == cme_pkg::FLT_NONE) f = cell_chk(w.da);
					if (f == cme_pkg::FLT_NONE) begin
						wr = 1; wi = w.da; wv = (cell_rd(w.sa) == 0) ? 64'd1 : 64'd0;
					end
				end
				default: f = cme_pkg::FLT_OP;
			endcase
		end
		if (f != cme_pkg::FLT_NONE) begin
			r.next_pc = pc; r.halted = 1'b1; r.fault_code = f;
			r.emit_kind = cme_pkg::EMIT_NONE; r.emit_value = '0;
			if (apply) begin halt = 1; flt = f; end
			return r;
		end
		r.next_pc = nxt[15:0]; r.halted = quit; r.fault_code = cme_pkg::FLT_NONE;
		r.emit_kind = ek; r.emit_value = ev;
		if (apply) begin
			if (wr) cells[ctx-1][wi[3:0]] = wv;
			if (cpush) begin
				for (int j = 0; j < NCELL; j++) cells[ctx][j] = '0;
				ctx_size[ctx] = w.imm[4:0];
				ctx++;
			end
			if (cpop) ctx--;
			if (apush) begin arg_stk[arg_sp] = pv; arg_sp++; end
			if (apop) arg_sp--;
			if (rpush) begin res_stk[res_sp] = pv; res_sp++; end
			if (rpop) res_sp--;
			if (kpush) begin ret_stk[ret_sp] = pc + 16'd1; ret_sp++; end
			if (kpop) ret_sp--;
			pc = nxt[15:0];
			if (quit) begin halt = 1; flt = cme_pkg::FLT_NONE; end
		end
		return r;
	endfunction

	function automatic instr_t mk(input logic [5:0] k, input logic [63:0] imm,
			input logic [7:0] sa, sb, sc, da, db, input logic [15:0] tpc);
		instr_t w;
		w.kind = k; w.imm = imm; w.sa = sa; w.sb = sb; w.sc = sc;
		w.da = da; w.db = db; w.tpc = tpc;
		return w;
	endfunction

	function automatic retire_t want(input logic [15:0] npc, input logic [1:0] ek,
			input logic [63:0] ev);
		retire_t r;
		r.next_pc = npc; r.halted = 1'b0; r.fault_code = cme_pkg::FLT_NONE;
		r.emit_kind = ek; r.emit_value = ev;
		return r;
	endfunction

	function automatic logic [7:0] pick_cell();
		int sz;
		sz = (ctx > 0) ? ctx_size[ctx-1] : 0;
		return (sz == 0) ? 8'($urandom_range(15)) : 8'($urandom_range(sz - 1));
	endfunction

	function automatic logic [63:0] pick_imm();
		case ($urandom_range(5))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1;
			3: return 64'($urandom_range(40));
			4: return {$urandom, $urandom};
			default: return 64'($urandom_range(65535));
		endcase
	endfunction

	// random instruction biased toward operands inside the open context
	function automatic instr_t draw_word();
		instr_t w;
		w.sa = pick_cell(); w.sb = pick_cell(); w.sc = pick_cell();
		w.da = pick_cell(); w.db = pick_cell();
		w.imm = pick_imm();
		w.tpc = 16'($urandom_range(65535));
		case ($urandom_range(20))
			0: w.kind = cme_pkg::K_WRITE;
			1: w.kind = cme_pkg::K_COPY;
			2: w.kind = cme_pkg::K_PRNUM;
			3: w.kind = cme_pkg::K_PRCHR;
			4: begin
				w.kind = cme_pkg::K_NEWCTX;
				w.imm = ($urandom_range(5) == 0) ? 64'd0 : 64'($urandom_range(1, NCELL));
			end
			5: w.kind = cme_pkg::K_DROPCX;
			6: w.kind = cme_pkg::K_PUSHA;
			7: w.kind = cme_pkg::K_POPA;
			8: w.kind = cme_pkg::K_PUSHR;
			9: w.kind = cme_pkg::K_POPR;
			10: w.kind = cme_pkg::K_CALL;
			11: w.kind = cme_pkg::K_RET;
			12: w.kind = cme_pkg::K_JUMP;
			13: w.kind = cme_pkg::K_RDPC;
			14: w.kind = cme_pkg::K_ADD;
			15: w.kind = cme_pkg::K_SUB;
			16: w.kind = cme_pkg::K_MUL;
			17: w.kind = cme_pkg::K_DIV;
			18: w.kind = cme_pkg::K_MOD;
			19: w.kind = cme_pkg::K_RANGE;
			default: w.kind = cme_pkg::K_NOT;
		endcase
		if (w.kind == cme_pkg::K_WRITE && $urandom_range(3) == 0)
			w.imm = 64'($urandom_range(3));	// small values feed jumps and divides
		return w;
	endfunction

	function automatic instr_t wild_word();
		return mk(6'($urandom), {$urandom, $urandom}, 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
	endfunction

	task automatic report(input string fld, input logic [63:0] got, input logic [63:0] exp_v);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, fld, got, exp_v);
		errors++;
	endtask

	// predicts, queues the expectation and offers the word until taken
	task automatic issue_word(input instr_t w, input bit typed, input retire_t typed_r);
		retire_t r;
		r = vm_execute(w, 1);
		retire_q.insert(retire_q.size(), typed ? typed_r : r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.kind; immediate <= w.imm;
		src_a <= w.sa; src_b <= w.sb; src_c <= w.sc;
		dst_a <= w.da; dst_b <= w.db; target_pc <= w.tpc;
		do @(posedge clk); while (in_stall);
	endtask

	// program length only changes with the machine idle
	task automatic write_len(input logic [15:0] v);
		in_valid <= 1'b0;
		while (retire_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		prog_len = v;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 56; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 56; end
			default: begin gap_pct = 11; stall_pct = 11; end
		endcase
	endtask

	// receiver: random stall, compare each taken word with the oldest expectation
	always @(posedge clk) begin
		retire_t e;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (out_valid && !out_stall) begin
			if (retire_q.size() == 0)
				report("unexpected word", {48'd0, next_pc}, 64'd0);
			else begin
				e = retire_q.pop_front();
				if (next_pc !== e.next_pc) report("next_pc", 64'(next_pc), 64'(e.next_pc));
				if (halted !== e.halted) report("halted", 64'(halted), 64'(e.halted));
				if (fault_code !== e.fault_code)
					report("fault_code", 64'(fault_code), 64'(e.fault_code));
				if (emit_kind !== e.emit_kind)
					report("emit_kind", 64'(emit_kind), 64'(e.emit_kind));
				if (emit_value !== e.emit_value)
					report("emit_value", emit_value, e.emit_value);
			end
		end
	end

	// watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		instr_t  w;
		retire_t r;
		bit      found;
		int      cause;

		// directed program, pc follows the row number until the jump
		dir_word[0]  = mk(cme_pkg::K_NEWCTX, 64'd16, 0, 0, 0, 0, 0, 0);
		dir_word[1]  = mk(cme_pkg::K_WRITE, '1, 0, 0, 0, 0, 0, 0);
		dir_word[2]  = mk(cme_pkg::K_WRITE, 64'd0, 0, 0, 0, 1, 0, 0);
		dir_word[3]  = mk(cme_pkg::K_WRITE, 64'd1, 0, 0, 0, 2, 0, 0);
		dir_word[4]  = mk(cme_pkg::K_PRNUM, 0, 0, 0, 0, 0, 0, 0);
		dir_word[5]  = mk(cme_pkg::K_PRCHR, 0, 0, 0, 0, 0, 0, 0);
		dir_word[6]  = mk(cme_pkg::K_ADD, 0, 0, 2, 0, 3, 0, 0);	// all ones plus one wraps
		dir_word[7]  = mk(cme_pkg::K_SUB, 0, 1, 2, 0, 4, 0, 0);	// zero minus one wraps
		dir_word[8]  = mk(cme_pkg::K_MUL, 0, 0, 0, 0, 5, 0, 0);
		dir_word[9]  = mk(cme_pkg::K_DIV, 0, 0, 1, 0, 6, 7, 0);	// zero divisor flags cell 7
		dir_word[10] = mk(cme_pkg::K_DIV, 0, 0, 2, 0, 8, 15, 0);
		dir_word[11] = mk(cme_pkg::K_MOD, 0, 4, 7, 0, 9, 15, 0);
		dir_word[12] = mk(cme_pkg::K_RANGE, 0, 1, 2, 0, 10, 0, 0);
		dir_word[13] = mk(cme_pkg::K_NOT, 0, 1, 0, 0, 11, 0, 0);
		dir_word[14] = mk(cme_pkg::K_PUSHA, 0, 0, 0, 0, 0, 0, 0);
		dir_word[15] = mk(cme_pkg::K_POPA, 0, 0, 0, 0, 12, 0, 0);
		dir_word[16] = mk(cme_pkg::K_PUSHR, 0, 2, 0, 0, 0, 0, 0);
		dir_word[17] = mk(cme_pkg::K_POPR, 0, 0, 0, 0, 13, 0, 0);
		dir_word[18] = mk(cme_pkg::K_RDPC, 0, 0, 0, 0, 14, 0, 0);
		dir_word[19] = mk(cme_pkg::K_JUMP, 0, 2, 0, 0, 0, 0, 16'd1000);	// cell holds exactly one
		dir_word[20] = mk(cme_pkg::K_WRITE, 64'd40000, 0, 0, 0, 15, 0, 0);
		dir_word[21] = mk(cme_pkg::K_CALL, 0, 15, 0, 0, 0, 0, 0);
		dir_word[22] = mk(cme_pkg::K_RET, 0, 0, 0, 0, 0, 0, 0);
		dir_word[23] = mk(cme_pkg::K_DROPCX, 0, 0, 0, 0, 0, 0, 0);
		dir_word[24] = mk(cme_pkg::K_NEWCTX, 64'd0, 0, 0, 0, 0, 0, 0);	// empty context is legal
		for (int i = 0; i < NDIR; i++) dir_typed[i] = 0;
		dir_typed[0]  = 1; dir_want[0]  = want(16'd1, cme_pkg::EMIT_NONE, 64'd0);
		dir_typed[1]  = 1; dir_want[1]  = want(16'd2, cme_pkg::EMIT_NONE, 64'd0);
		dir_typed[4]  = 1; dir_want[4]  = want(16'd5, cme_pkg::EMIT_NUM, '1);
		dir_typed[5]  = 1; dir_want[5]  = want(16'd6, cme_pkg::EMIT_CHR, 64'hFF);
		dir_typed[19] = 1; dir_want[19] = want(16'd1000, cme_pkg::EMIT_NONE, 64'd0);

		// single reset at the start of the run
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both length extremes; zero is only held while idle
		write_len(16'd0);
		write_len(16'hFFFF);

		set_idling(0);
		for (int i = 0; i < NDIR; i++)
			issue_word(dir_word[i], dir_typed[i], dir_want[i]);

		// random programs: only words that keep the machine running
		for (int ph = 0; ph < PHASES; ph++) begin
			set_idling(ph);
			if (ph > 0)
				write_len((ph % 2 == 0 || pc > 16'hF000) ? 16'hFFFF
					: 16'($urandom_range(65535, int'(pc) + 4000)));
			for (int n = 0; n < PER_PHASE; n++) begin
				found = 0;
				for (int t = 0; t < 200 && !found; t++) begin
					w = draw_word();
					r = vm_execute(w, 0);
					found = !r.halted && r.next_pc < prog_len;
				end
				if (!found) break;
				issue_word(w, 0, r);
			end
		end

		// one halting word, then words that must be ignored
		set_idling(3);
		cause = $urandom_range(3);
		case (cause)
			0: issue_word(mk(cme_pkg::K_QUIT, 0, 0, 0, 0, 0, 0, 0), 0, r);
			1: begin
				do w = wild_word();
				while (w.kind <= cme_pkg::K_NOT && w.kind != 6'd3 && w.kind != 6'd6
					&& (w.kind <= cme_pkg::K_RDPC || w.kind >= cme_pkg::K_ADD));
				issue_word(w, 0, r);	// unknown or left-out opcode
			end
			2: begin
				write_len(pc);	// counter now sits at the end of the program
				issue_word(draw_word(), 0, r);
			end
			default: begin
				found = 0;
				for (int t = 0; t < 500 && !found; t++) begin
					w = ($urandom_range(1)) ? wild_word() : draw_word();
					r = vm_execute(w, 0);
					found = r.halted;
				end
				if (!found) w = mk(6'd63, 0, 0, 0, 0, 0, 0, 0);
				issue_word(w, 0, r);
			end
		endcase
		for (int n = 0; n < 12; n++)
			issue_word(wild_word(), 0, r);
		in_valid <= 1'b0;

		while (retire_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
src/cme_pkg.sv
src/cme_muldiv.sv
src/cell_machine_execute_unit.sv
src/cme_checker.sv
test/cell_machine_execute_unit_tb.sv
